>>> sv/adc_ladder_key_qualifier_assert.svh
// Assertion macros shared by the ladder key qualifier.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ADC_LADDER_KEY_QUALIFIER_ASSERT_SVH
`define ADC_LADDER_KEY_QUALIFIER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define ALKQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ALKQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/alkq_pkg.sv
`timescale 1ns / 1ps
package alkq_pkg;

  localparam int DEF_WINDOW      = 5;
  localparam int DEF_MAP_ENTRIES = 64;
  localparam int COUNT_W         = 8;
  localparam int COUNT_LIMIT     = 200;
  localparam int CYCLE_SPAN      = 100;
  localparam int EARLY_MIN       = 3;
  localparam int SAMPLE_W        = 6;
  localparam int KEY_W           = 3;
  localparam int IN_BITS         = 10;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 8;

  localparam logic [SAMPLE_W-1:0] NO_KEY_SAMPLE = 6'h3f;
  localparam logic [KEY_W-1:0]    KEY_BEYOND    = 3'd7;

  // Result slots in the order they leave the block.
  localparam int SLOT_SAMPLE  = 0;
  localparam int SLOT_RELEASE = 1;
  localparam int SLOT_POWER_A = 2;
  localparam int SLOT_POWER_B = 3;
  localparam int SLOTS        = 4;

  typedef struct packed {
    logic                power_button_b;
    logic                power_button_a;
    logic                release_req;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_ready;
  } in_word_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [KEY_W-1:0] key_sample;
    logic [KEY_W-1:0] key_release;
  } res_bundle_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               held_valid;
  } core_status_t;

  // Ladder thresholds: each key covers a band of converter codes.
  function automatic logic [KEY_W-1:0] map_sample(input logic [SAMPLE_W-1:0] s,
                                                  input int entries);
    logic [KEY_W-1:0] k;
    if (int'(s) >= entries)  k = KEY_BEYOND;
    else if (s < 6'd8)       k = 3'd0;
    else if (s < 6'd15)      k = 3'd1;
    else if (s < 6'd22)      k = 3'd2;
    else if (s < 6'd28)      k = 3'd3;
    else if (s < 6'd34)      k = 3'd4;
    else if (s < 6'd40)      k = 3'd5;
    else if (s < 6'd50)      k = 3'd6;
    else                     k = 3'd7;
    return k;
  endfunction

endpackage

>>> sv/alkq_core.sv
`timescale 1ns / 1ps
module alkq_core #(
  parameter int WINDOW      = alkq_pkg::DEF_WINDOW,
  parameter int MAP_ENTRIES = alkq_pkg::DEF_MAP_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  alkq_pkg::in_word_t     item,
  output alkq_pkg::res_bundle_t  bundle,
  output alkq_pkg::core_status_t status
);
  import alkq_pkg::*;

  // The window is kept rotated so that entry 0 is the slot the next sample overwrites.
  localparam int WRAP_ROT = (WINDOW * CYCLE_SPAN - CYCLE_SPAN + 1) % WINDOW;

  logic [SAMPLE_W-1:0] win [WINDOW];
  logic [COUNT_W-1:0]  count;
  logic [KEY_W-1:0]    held_key;
  logic                held_valid;
  logic [SAMPLE_W-1:0] first0;
  logic [SAMPLE_W-1:0] first1;

  logic [SAMPLE_W-1:0] w      [WINDOW];
  logic [SAMPLE_W-1:0] w_rot  [WINDOW];
  logic [SAMPLE_W-1:0] w_wrap [WINDOW];
  logic [SAMPLE_W-1:0] win_next [WINDOW];
  logic                take;
  logic                full;
  logic                old_eq;
  logic                new_eq;
  logic                hit_s;
  logic [KEY_W-1:0]    key_s;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                wrapped;
  logic [COUNT_W-1:0]  cnt_s;
  logic [KEY_W-1:0]    held_key_s;
  logic                held_valid_s;
  logic [SAMPLE_W-1:0] f0_s;
  logic [SAMPLE_W-1:0] f1_s;
  logic                hit_r;
  logic [KEY_W-1:0]    key_r;

  always_comb begin
    take = item.sample_ready && (item.sample != NO_KEY_SAMPLE);
    for (int j = 0; j < WINDOW; j++) begin
      w[j] = win[j];
    end
    if (take) begin
      w[0] = item.sample;
    end
    for (int j = 0; j < WINDOW; j++) begin
      w_rot[j]  = w[(j + 1) % WINDOW];
      w_wrap[j] = w[(j + WRAP_ROT) % WINDOW];
    end

    full   = count >= COUNT_W'(WINDOW - 1);
    old_eq = w[1] == w[2];
    new_eq = w[WINDOW-1] == w[0];
    hit_s  = take && full && (old_eq || new_eq);
    key_s  = map_sample(old_eq ? w[1] : w[0], MAP_ENTRIES);

    cnt_inc = count + COUNT_W'(1);
    wrapped = cnt_inc > COUNT_W'(COUNT_LIMIT);
    if (!take)        cnt_s = count;
    else if (wrapped) cnt_s = cnt_inc - COUNT_W'(CYCLE_SPAN);
    else              cnt_s = cnt_inc;

    held_key_s   = hit_s ? key_s : held_key;
    held_valid_s = held_valid || hit_s;
    f0_s = (take && count == COUNT_W'(0)) ? item.sample : first0;
    f1_s = (take && count == COUNT_W'(1)) ? item.sample : first1;

    if (cnt_s > COUNT_W'(WINDOW)) begin
      hit_r = held_valid_s;
      key_r = held_key_s;
    end else begin
      hit_r = (cnt_s >= COUNT_W'(EARLY_MIN - 1)) && (f0_s == f1_s);
      key_r = map_sample(f0_s, MAP_ENTRIES);
    end
    hit_r = hit_r && item.release_req;

    for (int j = 0; j < WINDOW; j++) begin
      if (item.release_req)  win_next[j] = '0;
      else if (!take)        win_next[j] = win[j];
      else if (wrapped)      win_next[j] = w_wrap[j];
      else                   win_next[j] = w_rot[j];
    end

    bundle.mask[SLOT_SAMPLE]  = hit_s;
    bundle.mask[SLOT_RELEASE] = hit_r;
    bundle.mask[SLOT_POWER_A] = item.power_button_a;
    bundle.mask[SLOT_POWER_B] = item.power_button_b;
    bundle.key_sample         = key_s;
    bundle.key_release        = key_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < WINDOW; j++) begin
        win[j] <= '0;
      end
      count      <= '0;
      held_key   <= '0;
      held_valid <= 1'b0;
      first0     <= '0;
      first1     <= '0;
    end else if (fire) begin
      for (int j = 0; j < WINDOW; j++) begin
        win[j] <= win_next[j];
      end
      held_key <= held_key_s;
      if (item.release_req) begin
        count      <= '0;
        held_valid <= 1'b0;
        first0     <= '0;
        first1     <= '0;
      end else begin
        count      <= cnt_s;
        held_valid <= held_valid_s;
        first0     <= f0_s;
        first1     <= f1_s;
      end
    end
  end

  assign status.count      = count;
  assign status.held_valid = held_valid;

endmodule

>>> sv/alkq_out.sv
`timescale 1ns / 1ps
module alkq_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  alkq_pkg::res_bundle_t              bundle_in,
  output logic                               free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [alkq_pkg::OUT_TDATA_W-1:0]   m_tdata,  // key_index[2:0], zeros above
  output logic                               m_tuser,  // is_power
  output logic                               m_tlast
);
  import alkq_pkg::*;

  logic [SLOTS-1:0] mask;
  logic [SLOTS-1:0] mask_next;
  logic [SLOTS-1:0] rest;
  logic [KEY_W-1:0] key_sample;
  logic [KEY_W-1:0] key_release;
  logic [KEY_W-1:0] key_cur;
  logic             hs;

  always_comb begin
    rest     = mask & (mask - SLOTS'(1));
    m_tvalid = |mask;
    hs       = m_tvalid && m_tready;
    m_tlast  = rest == '0;
    free     = !m_tvalid || (hs && m_tlast);
    if (mask[SLOT_SAMPLE]) begin
      key_cur = key_sample;
      m_tuser = 1'b0;
    end else if (mask[SLOT_RELEASE]) begin
      key_cur = key_release;
      m_tuser = 1'b0;
    end else begin
      key_cur = '0;
      m_tuser = 1'b1;
    end
    m_tdata = OUT_TDATA_W'(key_cur);
    if (load)    mask_next = bundle_in.mask;
    else if (hs) mask_next = rest;
    else         mask_next = mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_sample  <= bundle_in.key_sample;
      key_release <= bundle_in.key_release;
    end
  end

endmodule

>>> sv/adc_ladder_key_qualifier.sv
`timescale 1ns / 1ps
// Channel  Direction  Word contents (from bit 0 up)
// s_axis   in         sample_ready, sample[5:0], release_req, power_button_a, power_button_b
// m_axis   out        tdata: key_index[2:0]; tuser: is_power; tlast: last
//
// A word waits in the input register until the result register is free and is then processed as it is loaded.
// It yields zero to four results, sent one per cycle from the result register while m_tready is high.
// A new word is taken every cycle while each word yields at most one result and m_tready is high;
// otherwise a word is taken only as the last result of the one before is sent on the single output port.
// Reset is synchronous and clears the window, the count and the held key.
`include "adc_ladder_key_qualifier_assert.svh"
module adc_ladder_key_qualifier #(
  parameter int WINDOW      = alkq_pkg::DEF_WINDOW,
  parameter int MAP_ENTRIES = alkq_pkg::DEF_MAP_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [alkq_pkg::IN_TDATA_W-1:0]  s_tdata,  // sample_ready, sample[5:0], release_req,
                                                     // power_button_a, power_button_b, zeros
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [alkq_pkg::OUT_TDATA_W-1:0] m_tdata,  // key_index[2:0], zeros above
  output logic                             m_tuser,  // is_power
  output logic                             m_tlast
);
  import alkq_pkg::*;

  logic         in_full;
  in_word_t     in_word;
  logic         out_free;
  logic         fire;
  res_bundle_t  bundle;
  core_status_t status;

  assign s_tready = !in_full || out_free;
  assign fire     = in_full && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= in_word_t'(s_tdata[IN_BITS-1:0]);
    end
  end

  alkq_core #(
    .WINDOW      (WINDOW),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_word),
    .bundle (bundle),
    .status (status)
  );

  alkq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle_in (bundle),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  `ALKQ_ASSERT_NEXT(a_word_kept, in_full && !out_free, in_full, "pending word dropped")
  `ALKQ_ASSERT_NEXT(a_more_follow, m_tvalid && m_tready && !m_tlast, m_tvalid, "results lost")
  `ALKQ_ASSERT_ALWAYS(a_count_range, status.count <= COUNT_W'(COUNT_LIMIT), "count out of range")

endmodule
